### sv/pair_shell_ion_count_stats_top_defines.svh
// pair_shell_ion_count_stats_top_defines.svh
// assertion macros for the pair shell ion counter, no other dependencies
`ifndef PAIR_SHELL_ION_COUNT_STATS_TOP_DEFINES_SVH
`define PAIR_SHELL_ION_COUNT_STATS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSICS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSICS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/psics_pkg.sv
// psics_pkg.sv
// shared constants, command codes and controller/datapath structs
// no dependencies
`default_nettype none
package psics_pkg;

  localparam int unsigned ION_CAP   = 256;
  localparam int unsigned FRAME_CAP = 16384;

  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [22:0] MAX23 = 23'h7F_FFFF;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [53:0] MAX54 = 54'h3F_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_WEIGHT = 1'b1;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MS_NONE, MS_DX1, MS_DY1, MS_DZ1, MS_DX2, MS_DY2, MS_DZ2, MS_RAD,
    MS_CNT, MS_HH, MS_HL, MS_LH, MS_LL, MS_MEAN
  } ms_t;

  // divider operand selection
  typedef enum logic [2:0] {
    DV_TERM, DV_CMEAN, DV_EX2, DV_IMEAN, DV_ISQ
  } dv_t;

  // result store selection
  typedef enum logic [2:0] {
    ST_NONE, ST_CMEAN, ST_EX2, ST_IMEAN, ST_ISQ, ST_CDEV, ST_IDEV
  } st_t;

  typedef struct packed {
    logic load;
    ms_t  ms;
    logic wsq_mean;
    logic wacc_clr;
    logic count_upd;
    logic div_start;
    dv_t  dv;
    logic acc_term;
    logic fold;
    st_t  st;
    logic sqrt_start;
    logic sqrt_ivar;
    logic clear_stats;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic series_end;
    logic div_busy;
    logic sqrt_busy;
  } stat_t;

endpackage
`default_nettype wire

### sv/psics_div.sv
// psics_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none
module psics_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [44:0] divisor,
  input  logic [6:0]  iters,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] dvd;
  logic [44:0] dsr;
  logic [44:0] rem;
  logic [6:0]  cnt;
  logic [45:0] rem_sh;
  logic        take;

  // trial subtract
  assign rem_sh = {rem, dvd[63]};
  assign take   = rem_sh >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[62:0], 1'b0};
      rem      <= take ? 45'(rem_sh - {1'b0, dsr}) : rem_sh[44:0];
      quotient <= {quotient[62:0], take};
    end
  end

endmodule
`default_nettype wire

### sv/psics_sqrt.sv
// psics_sqrt.sv
// digit-by-digit floor square root of a 64-bit value, one root bit per cycle
// no package dependencies
`default_nettype none
module psics_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  // trial subtract
  assign rem_sh = {rem, v[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v    <= {v[61:0], 2'b00};
      rem  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
      root <= {root[30:0], take};
    end
  end

endmodule
`default_nettype wire

### sv/psics_dp.sv
// psics_dp.sv
// datapath: distances, shared multiplier, divider, square root, sums, results
// depends on psics_pkg, psics_div, psics_sqrt
`default_nettype none
module psics_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  psics_pkg::cmd_t       cmd,
  output psics_pkg::stat_t      stat,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [19:0]           cfg_data,
  input  logic signed [20:0]    ion_x,
  input  logic signed [20:0]    ion_y,
  input  logic signed [20:0]    ion_z,
  input  logic signed [20:0]    first_x,
  input  logic signed [20:0]    first_y,
  input  logic signed [20:0]    first_z,
  input  logic signed [20:0]    second_x,
  input  logic signed [20:0]    second_y,
  input  logic signed [20:0]    second_z,
  input  logic                  last_of_frame,
  input  logic                  last_of_series,
  output logic [8:0]            frame_count,
  output logic [39:0]           frame_intensity,
  output logic                  is_final,
  output logic [24:0]           count_mean,
  output logic [24:0]           count_deviation,
  output logic [39:0]           intensity_mean,
  output logic [39:0]           intensity_deviation
);
  import psics_pkg::*;

  function automatic logic [20:0] abs_diff(input logic signed [20:0] a,
                                           input logic signed [20:0] b);
    logic [21:0] d;
    d = {a[20], a} - {b[20], b};
    return d[21] ? 21'(~d + 22'd1) : d[20:0];
  endfunction

  logic [19:0] radius;
  logic [2:0]  charge_weight;
  logic [20:0] adx1, ady1, adz1, adx2, ady2, adz2;
  logic        fe, se;
  logic [43:0] d1, d2;
  logic [39:0] r2;
  logic [63:0] prod;
  ms_t         tag;
  logic [31:0] opa, opb;
  logic [39:0] wsrc;
  logic [8:0]  frame_cnt;
  logic [39:0] frame_sum;
  logic [16:0] cnt_sq;
  logic [47:0] wacc;
  logic [22:0] count_total;
  logic [30:0] count_square_total;
  logic [53:0] intensity_total;
  logic [63:0] intensity_square_total;
  logic [14:0] frames_seen;
  logic [48:0] ex2, msq, cvar;
  logic [47:0] isq, ivar;
  logic [44:0] dsum;
  logic [39:0] term;
  logic [40:0] fsum;
  logic [23:0] ct_sum;
  logic [31:0] cst_sum;
  logic [54:0] it_sum;
  logic [64:0] ist_sum;
  logic [63:0] div_dvd;
  logic [44:0] div_dsr;
  logic [6:0]  div_iters;
  logic        div_busy, sqrt_busy;
  logic [63:0] quo;
  logic [31:0] root;
  logic [63:0] sqrt_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= 20'd2048;
      charge_weight <= 3'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIUS: radius        <= cfg_data;
        REG_WEIGHT: charge_weight <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adx1 <= abs_diff(ion_x, first_x);
      ady1 <= abs_diff(ion_y, first_y);
      adz1 <= abs_diff(ion_z, first_z);
      adx2 <= abs_diff(ion_x, second_x);
      ady2 <= abs_diff(ion_y, second_y);
      adz2 <= abs_diff(ion_z, second_z);
      fe   <= last_of_frame | last_of_series;
      se   <= last_of_series;
    end
  end

  // multiplier operands
  assign wsrc = cmd.wsq_mean ? intensity_mean : frame_sum;
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.ms)
      MS_DX1:  begin opa = 32'(adx1); opb = 32'(adx1); end
      MS_DY1:  begin opa = 32'(ady1); opb = 32'(ady1); end
      MS_DZ1:  begin opa = 32'(adz1); opb = 32'(adz1); end
      MS_DX2:  begin opa = 32'(adx2); opb = 32'(adx2); end
      MS_DY2:  begin opa = 32'(ady2); opb = 32'(ady2); end
      MS_DZ2:  begin opa = 32'(adz2); opb = 32'(adz2); end
      MS_RAD:  begin opa = 32'(radius); opb = 32'(radius); end
      MS_CNT:  begin opa = 32'(frame_cnt); opb = 32'(frame_cnt); end
      MS_HH:   begin opa = 32'(wsrc[39:32]); opb = 32'(wsrc[39:32]); end
      MS_HL:   begin opa = 32'(wsrc[39:32]); opb = wsrc[31:0]; end
      MS_LH:   begin opa = wsrc[31:0]; opb = 32'(wsrc[39:32]); end
      MS_LL:   begin opa = wsrc[31:0]; opb = wsrc[31:0]; end
      MS_MEAN: begin opa = 32'(count_mean); opb = 32'(count_mean); end
      default: ;
    endcase
  end

  // registered product and its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= MS_NONE;
    end else begin
      tag <= cmd.ms;
    end
    if (cmd.ms != MS_NONE) begin
      prod <= opa * opb;
    end
  end

  // product accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d1 <= '0;
      d2 <= '0;
    end
    if (cmd.wacc_clr) begin
      wacc <= '0;
    end
    case (tag)
      MS_DX1, MS_DY1, MS_DZ1: d1 <= d1 + prod[43:0];
      MS_DX2, MS_DY2, MS_DZ2: d2 <= d2 + prod[43:0];
      MS_RAD:  r2 <= prod[39:0];
      MS_CNT:  cnt_sq <= prod[16:0];
      MS_HH:   wacc <= wacc + {prod[15:0], 32'd0};
      MS_HL, MS_LH: wacc <= wacc + 48'(prod[39:0]);
      MS_LL:   wacc <= wacc + 48'(prod[63:32]);
      MS_MEAN: msq <= prod[48:0];
      default: ;
    endcase
  end

  // intensity term from divider quotient
  assign dsum = {1'b0, d1} + {1'b0, d2};
  always_comb begin
    if (dsum == '0) begin
      term = (charge_weight != 3'd0) ? MAX40 : '0;
    end else if (|quo[63:40]) begin
      term = MAX40;
    end else begin
      term = quo[39:0];
    end
  end
  assign fsum = {1'b0, frame_sum} + {1'b0, term};

  // divider operand selection
  always_comb begin
    div_dsr = dsum;
    case (cmd.dv)
      DV_TERM:  begin div_dvd = {charge_weight, 61'd0}; div_iters = 7'd43; end
      DV_CMEAN: begin div_dvd = {count_total, 41'd0}; div_iters = 7'd39; end
      DV_EX2:   begin div_dvd = {count_square_total, 33'd0}; div_iters = 7'd63; end
      DV_IMEAN: begin div_dvd = {intensity_total, 10'd0}; div_iters = 7'd54; end
      DV_ISQ:   begin div_dvd = intensity_square_total; div_iters = 7'd64; end
      default:  begin div_dvd = '0; div_iters = 7'd1; end
    endcase
    if (cmd.dv != DV_TERM) begin
      div_dsr = 45'(frames_seen);
    end
  end

  psics_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .iters    (div_iters),
    .busy     (div_busy),
    .quotient (quo)
  );

  // variances
  assign cvar     = (ex2 > msq) ? 49'(ex2 - msq) : '0;
  assign ivar     = (isq > wacc) ? 48'(isq - wacc) : '0;
  assign sqrt_val = cmd.sqrt_ivar ? {ivar, 16'd0} : 64'(cvar);

  psics_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value (sqrt_val),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // saturating sums
  assign ct_sum  = {1'b0, count_total} + 24'(frame_cnt);
  assign cst_sum = {1'b0, count_square_total} + 32'(cnt_sq);
  assign it_sum  = {1'b0, intensity_total} + 55'(frame_sum);
  assign ist_sum = {1'b0, intensity_square_total} + 65'(wacc);

  // frame and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt              <= '0;
      frame_sum              <= '0;
      count_total            <= '0;
      count_square_total     <= '0;
      intensity_total        <= '0;
      intensity_square_total <= '0;
      frames_seen            <= '0;
    end else begin
      if (cmd.count_upd && d1 < 44'(r2) && d2 < 44'(r2) && frame_cnt < 9'(ION_CAP)) begin
        frame_cnt <= frame_cnt + 9'd1;
      end
      if (cmd.acc_term) begin
        frame_sum <= fsum[40] ? MAX40 : fsum[39:0];
      end
      if (cmd.fold) begin
        frame_cnt <= '0;
        frame_sum <= '0;
        if (frames_seen < 15'(FRAME_CAP)) begin
          frames_seen            <= frames_seen + 15'd1;
          count_total            <= (ct_sum > 24'(MAX23)) ? MAX23 : ct_sum[22:0];
          count_square_total     <= (cst_sum > 32'(MAX31)) ? MAX31 : cst_sum[30:0];
          intensity_total        <= (it_sum > 55'(MAX54)) ? MAX54 : it_sum[53:0];
          intensity_square_total <= ist_sum[64] ? MAX64 : ist_sum[63:0];
        end
      end
      if (cmd.clear_stats) begin
        count_total            <= '0;
        count_square_total     <= '0;
        intensity_total        <= '0;
        intensity_square_total <= '0;
        frames_seen            <= '0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      is_final <= 1'b0;
    end else if (cmd.fold) begin
      is_final <= 1'b0;
    end else if (cmd.st == ST_IDEV) begin
      is_final <= 1'b1;
    end
    if (cmd.fold) begin
      frame_count         <= frame_cnt;
      frame_intensity     <= frame_sum;
      count_mean          <= '0;
      count_deviation     <= '0;
      intensity_mean      <= '0;
      intensity_deviation <= '0;
    end
    case (cmd.st)
      ST_CMEAN: count_mean          <= quo[24:0];
      ST_EX2:   ex2                 <= quo[48:0];
      ST_IMEAN: intensity_mean      <= quo[39:0];
      ST_ISQ:   isq                 <= quo[47:0];
      ST_CDEV:  count_deviation     <= root[24:0];
      ST_IDEV:  intensity_deviation <= {root, 8'd0};
      default: ;
    endcase
  end

  // status to controller
  assign stat.frame_end  = fe;
  assign stat.series_end = se;
  assign stat.div_busy   = div_busy;
  assign stat.sqrt_busy  = sqrt_busy;

endmodule
`default_nettype wire

### sv/psics_ctrl.sv
// psics_ctrl.sv
// controller: sequences multiplier and divider steps per item, and square root steps at a series end
// depends on psics_pkg and the assertion macro header
`default_nettype none
`include "pair_shell_ion_count_stats_top_defines.svh"
module psics_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  psics_pkg::stat_t stat,
  output psics_pkg::cmd_t  cmd
);
  import psics_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_TDIV  = 6'b000100,
    S_TWAIT = 6'b001000,
    S_FOLD  = 6'b010000,
    S_SER   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic       out_set;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    out_set    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
          step_next  = '0;
        end
      end
      // six squared differences, then radius squared
      S_MUL: begin
        case (step)
          5'd0: cmd.ms = MS_DX1;
          5'd1: cmd.ms = MS_DY1;
          5'd2: cmd.ms = MS_DZ1;
          5'd3: cmd.ms = MS_DX2;
          5'd4: cmd.ms = MS_DY2;
          5'd5: cmd.ms = MS_DZ2;
          5'd6: cmd.ms = MS_RAD;
          default: ;
        endcase
        if (step == 5'd7) begin
          state_next = S_TDIV;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_TDIV: begin
        cmd.count_upd = 1'b1;
        cmd.div_start = 1'b1;
        cmd.dv        = DV_TERM;
        state_next    = S_TWAIT;
      end
      S_TWAIT: begin
        if (!stat.div_busy) begin
          cmd.acc_term = 1'b1;
          step_next    = '0;
          state_next   = stat.frame_end ? S_FOLD : S_IDLE;
        end
      end
      // count square and intensity square, then fold into totals
      S_FOLD: begin
        case (step)
          5'd0: begin cmd.wacc_clr = 1'b1; cmd.ms = MS_CNT; end
          5'd1: cmd.ms = MS_HH;
          5'd2: cmd.ms = MS_HL;
          5'd3: cmd.ms = MS_LH;
          5'd4: cmd.ms = MS_LL;
          default: ;
        endcase
        if (step == 5'd6) begin
          if (out_free) begin
            cmd.fold   = 1'b1;
            out_set    = !stat.series_end;
            step_next  = '0;
            state_next = stat.series_end ? S_SER : S_IDLE;
          end
        end else begin
          step_next = step + 5'd1;
        end
      end
      // series statistics
      S_SER: begin
        step_next = step + 5'd1;
        case (step)
          5'd0: begin cmd.div_start = 1'b1; cmd.dv = DV_CMEAN; end
          5'd1: begin
            if (stat.div_busy) step_next = step;
            else cmd.st = ST_CMEAN;
          end
          5'd2: begin cmd.div_start = 1'b1; cmd.dv = DV_EX2; end
          5'd3: begin
            if (stat.div_busy) step_next = step;
            else cmd.st = ST_EX2;
          end
          5'd4: cmd.ms = MS_MEAN;
          5'd6: begin cmd.div_start = 1'b1; cmd.dv = DV_IMEAN; end
          5'd7: begin
            if (stat.div_busy) step_next = step;
            else cmd.st = ST_IMEAN;
          end
          5'd8: begin cmd.wacc_clr = 1'b1; cmd.wsq_mean = 1'b1; cmd.ms = MS_HH; end
          5'd9: begin cmd.wsq_mean = 1'b1; cmd.ms = MS_HL; end
          5'd10: begin cmd.wsq_mean = 1'b1; cmd.ms = MS_LH; end
          5'd11: begin cmd.wsq_mean = 1'b1; cmd.ms = MS_LL; end
          5'd13: begin cmd.div_start = 1'b1; cmd.dv = DV_ISQ; end
          5'd14: begin
            if (stat.div_busy) step_next = step;
            else cmd.st = ST_ISQ;
          end
          5'd15: cmd.sqrt_start = 1'b1;
          5'd16: begin
            if (stat.sqrt_busy) step_next = step;
            else cmd.st = ST_CDEV;
          end
          5'd17: begin cmd.sqrt_start = 1'b1; cmd.sqrt_ivar = 1'b1; end
          5'd18: begin
            if (!stat.sqrt_busy) begin
              cmd.st          = ST_IDEV;
              cmd.clear_stats = 1'b1;
              out_set         = 1'b1;
              state_next      = S_IDLE;
            end else begin
              step_next = step;
            end
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `PSICS_ASSERT_NOW(a_idle_units_free, state == S_IDLE, !stat.div_busy && !stat.sqrt_busy, "unit busy while idle")
  `PSICS_ASSERT_NEXT(a_div_started, cmd.div_start, stat.div_busy, "divider did not start")
  `PSICS_ASSERT_NEXT(a_frame_result, cmd.fold && !stat.series_end, out_valid, "frame item lost")
  `PSICS_ASSERT_NOW(a_fold_out_free, cmd.fold, out_free, "result overwritten")

endmodule
`default_nettype wire

### sv/pair_shell_ion_count_stats_top.sv
// a frame-closing item is accepted, then passes load, the multiply steps, divider start,
// the term division and the fold steps before its result is shown
// a series end adds four divisions and two square roots;
// a stalled result holds the fold step and the input with it
// one ion at a time: a new ion is taken only once the controller is back in idle
// reset: synchronous, clears counts, sums and the pending result; radius 2048, weight 1
`default_nettype none
module pair_shell_ion_count_stats_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [20:0] ion_x,
  input  logic signed [20:0] ion_y,
  input  logic signed [20:0] ion_z,
  input  logic signed [20:0] first_x,
  input  logic signed [20:0] first_y,
  input  logic signed [20:0] first_z,
  input  logic signed [20:0] second_x,
  input  logic signed [20:0] second_y,
  input  logic signed [20:0] second_z,
  input  logic               last_of_frame,
  input  logic               last_of_series,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         frame_count,
  output logic [39:0]        frame_intensity,
  output logic               is_final,
  output logic [24:0]        count_mean,
  output logic [24:0]        count_deviation,
  output logic [39:0]        intensity_mean,
  output logic [39:0]        intensity_deviation
);
  import psics_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  psics_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  psics_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .ion_x               (ion_x),
    .ion_y               (ion_y),
    .ion_z               (ion_z),
    .first_x             (first_x),
    .first_y             (first_y),
    .first_z             (first_z),
    .second_x            (second_x),
    .second_y            (second_y),
    .second_z            (second_z),
    .last_of_frame       (last_of_frame),
    .last_of_series      (last_of_series),
    .frame_count         (frame_count),
    .frame_intensity     (frame_intensity),
    .is_final            (is_final),
    .count_mean          (count_mean),
    .count_deviation     (count_deviation),
    .intensity_mean      (intensity_mean),
    .intensity_deviation (intensity_deviation)
  );

endmodule
`default_nettype wire
